// ===== design/sia_pkg.sv =====
`default_nettype none

package sia_pkg;

    localparam int XLEN = 64;

    localparam logic [4:0] OP_UDIV = 5'd0;
    localparam logic [4:0] OP_SDIV = 5'd1;
    localparam logic [4:0] OP_UREM = 5'd2;
    localparam logic [4:0] OP_SREM = 5'd3;
    localparam logic [4:0] OP_MUL  = 5'd4;
    localparam logic [4:0] OP_SHL  = 5'd5;
    localparam logic [4:0] OP_LSHR = 5'd6;
    localparam logic [4:0] OP_ASHR = 5'd7;
    localparam logic [4:0] OP_AND  = 5'd8;
    localparam logic [4:0] OP_OR   = 5'd9;
    localparam logic [4:0] OP_XOR  = 5'd10;
    localparam logic [4:0] OP_ADD  = 5'd11;
    localparam logic [4:0] OP_SUB  = 5'd12;
    localparam logic [4:0] OP_EQ   = 5'd13;
    localparam logic [4:0] OP_NE   = 5'd14;
    localparam logic [4:0] OP_UGT  = 5'd15;
    localparam logic [4:0] OP_UGE  = 5'd16;
    localparam logic [4:0] OP_ULT  = 5'd17;
    localparam logic [4:0] OP_ULE  = 5'd18;
    localparam logic [4:0] OP_SGT  = 5'd19;
    localparam logic [4:0] OP_SGE  = 5'd20;
    localparam logic [4:0] OP_SLT  = 5'd21;
    localparam logic [4:0] OP_SLE  = 5'd22;

    localparam logic [2:0] W_1  = 3'd0;
    localparam logic [2:0] W_8  = 3'd1;
    localparam logic [2:0] W_16 = 3'd2;
    localparam logic [2:0] W_32 = 3'd3;

    typedef enum logic [1:0] {
        KIND_ALU,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [4:0]        cmd;
        logic [2:0]        wsel;
        logic [XLEN-1:0]   a;
        logic [XLEN-1:0]   b;
    } alu_item_t;

    function automatic logic [XLEN-1:0] width_mask(input logic [2:0] wsel);
        logic [XLEN-1:0] m;
        case (wsel)
            W_1:     m = 64'h0000_0000_0000_0001;
            W_8:     m = 64'h0000_0000_0000_00ff;
            W_16:    m = 64'h0000_0000_0000_ffff;
            W_32:    m = 64'h0000_0000_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/sia_front.sv =====
`default_nettype none

module sia_front
    import sia_pkg::*;
(
    input  wire logic [4:0]      s_cmd,
    input  wire logic [2:0]      s_width_sel,
    input  wire logic [XLEN-1:0] s_operand_a,
    input  wire logic [XLEN-1:0] s_operand_b,
    output alu_item_t            item
);

    logic            sgn;
    logic            is_shift;
    logic [XLEN-1:0] a_ext;
    logic [XLEN-1:0] b_ext;
    logic [XLEN-1:0] shamt;
    kind_t           kind;

    function automatic logic [XLEN-1:0] extend(input logic [XLEN-1:0] v,
                                               input logic [2:0] wsel,
                                               input logic s);
        logic [XLEN-1:0] t;
        case (wsel)
            W_1:     t = {{63{s & v[0]}}, v[0]};
            W_8:     t = {{56{s & v[7]}}, v[7:0]};
            W_16:    t = {{48{s & v[15]}}, v[15:0]};
            W_32:    t = {{32{s & v[31]}}, v[31:0]};
            default: t = v;
        endcase
        return t;
    endfunction

    always_comb begin
        sgn = (s_cmd == OP_SDIV) || (s_cmd == OP_SREM) || (s_cmd == OP_ASHR) ||
              (s_cmd == OP_SGT) || (s_cmd == OP_SGE) || (s_cmd == OP_SLT) ||
              (s_cmd == OP_SLE);
        is_shift = (s_cmd == OP_SHL) || (s_cmd == OP_LSHR) || (s_cmd == OP_ASHR);
        a_ext = extend(s_operand_a, s_width_sel, sgn);
        b_ext = extend(s_operand_b, s_width_sel, sgn);
        // shift amount wraps at the operand width
        case (s_width_sel)
            W_1:     shamt = '0;
            W_8:     shamt = {61'b0, s_operand_b[2:0]};
            W_16:    shamt = {60'b0, s_operand_b[3:0]};
            W_32:    shamt = {59'b0, s_operand_b[4:0]};
            default: shamt = {58'b0, s_operand_b[5:0]};
        endcase
        if (s_cmd == OP_UDIV || s_cmd == OP_SDIV || s_cmd == OP_UREM || s_cmd == OP_SREM) begin
            kind = KIND_DIV;
        end else if (s_cmd == OP_MUL) begin
            kind = KIND_MUL;
        end else begin
            kind = KIND_ALU;
        end
        item.kind = kind;
        item.cmd  = s_cmd;
        item.wsel = s_width_sel;
        item.a    = a_ext;
        item.b    = is_shift ? shamt : b_ext;
    end

endmodule

`default_nettype wire

// ===== design/sia_fifo.sv =====
`default_nettype none

module sia_fifo
    import sia_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire alu_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output alu_item_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    alu_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/sia_back.sv =====
`default_nettype none

module sia_back
    import sia_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire alu_item_t       q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [XLEN-1:0]      m_result,
    output logic                 m_div_by_zero
);

    localparam logic [6:0] DIV_STEPS = 7'd64;
    localparam logic [XLEN-1:0] SIGN = {1'b1, 63'b0};

    // stage 1: operands, divider state
    logic            s1_valid_reg;
    alu_item_t       s1_reg;
    logic [6:0]      cnt_reg, cnt_next;
    logic [XLEN-1:0] rem_reg, rem_next;
    logic [XLEN-1:0] quo_reg, quo_next;
    logic [XLEN-1:0] dvs_reg, dvs_next;
    logic            negq_reg, negq_next;
    logic            negr_reg, negr_next;
    logic            dz_reg, dz_next;

    // stage 2: result or partial products
    logic            s2_valid_reg;
    logic            s2_mul_reg;
    logic [2:0]      s2_wsel_reg;
    logic [XLEN-1:0] s2_r_reg;
    logic [XLEN-1:0] s2_pp0_reg;
    logic [31:0]     s2_pp1_reg;
    logic [31:0]     s2_pp2_reg;
    logic            s2_dz_reg;

    logic            out_valid_reg;
    logic [XLEN-1:0] out_result_reg;
    logic            out_dz_reg;

    logic            out_free, s2_free, s1_done, s1_go, s1_free;
    logic            ld_sgn;
    logic [XLEN-1:0] ld_ma, ld_mb;
    logic [XLEN:0]   rem_sh, diff;
    logic [XLEN-1:0] alu_r, div_r, final_r;
    logic            slt_ab, slt_ba;

    assign out_free = !out_valid_reg || m_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_done  = s1_valid_reg && ((s1_reg.kind != KIND_DIV) || (cnt_reg == '0));
    assign s1_go    = s1_done && s2_free;
    assign s1_free  = !s1_valid_reg || s1_go;
    assign q_pop    = q_valid && s1_free;

    assign m_valid       = out_valid_reg;
    assign m_result      = out_result_reg;
    assign m_div_by_zero = out_dz_reg;

    // divider: one quotient bit per cycle, restoring
    always_comb begin
        ld_sgn = (q_item.cmd == OP_SDIV) || (q_item.cmd == OP_SREM);
        ld_ma  = (ld_sgn && q_item.a[63]) ? (64'd0 - q_item.a) : q_item.a;
        ld_mb  = (ld_sgn && q_item.b[63]) ? (64'd0 - q_item.b) : q_item.b;
        rem_sh = {rem_reg, quo_reg[63]};
        diff   = rem_sh - {1'b0, dvs_reg};

        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        dz_next   = dz_reg;
        if (q_pop) begin
            dz_next   = (q_item.kind == KIND_DIV) && (q_item.b == '0);
            cnt_next  = (q_item.kind == KIND_DIV && q_item.b != '0) ? DIV_STEPS : '0;
            rem_next  = '0;
            quo_next  = ld_ma;
            dvs_next  = ld_mb;
            negq_next = ld_sgn && (q_item.a[63] ^ q_item.b[63]);
            negr_next = ld_sgn && q_item.a[63];
        end else if (s1_valid_reg && cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[XLEN]) begin
                rem_next = diff[XLEN-1:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = rem_sh[XLEN-1:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_comb begin
        slt_ab = (s1_reg.a ^ SIGN) < (s1_reg.b ^ SIGN);
        slt_ba = (s1_reg.b ^ SIGN) < (s1_reg.a ^ SIGN);
        case (s1_reg.cmd)
            OP_SHL:  alu_r = s1_reg.a << s1_reg.b[5:0];
            OP_LSHR: alu_r = s1_reg.a >> s1_reg.b[5:0];
            OP_ASHR: alu_r = $unsigned($signed(s1_reg.a) >>> s1_reg.b[5:0]);
            OP_AND:  alu_r = s1_reg.a & s1_reg.b;
            OP_OR:   alu_r = s1_reg.a | s1_reg.b;
            OP_XOR:  alu_r = s1_reg.a ^ s1_reg.b;
            OP_ADD:  alu_r = s1_reg.a + s1_reg.b;
            OP_SUB:  alu_r = s1_reg.a - s1_reg.b;
            OP_EQ:   alu_r = {63'b0, s1_reg.a == s1_reg.b};
            OP_NE:   alu_r = {63'b0, s1_reg.a != s1_reg.b};
            OP_UGT:  alu_r = {63'b0, s1_reg.a > s1_reg.b};
            OP_UGE:  alu_r = {63'b0, s1_reg.a >= s1_reg.b};
            OP_ULT:  alu_r = {63'b0, s1_reg.a < s1_reg.b};
            OP_ULE:  alu_r = {63'b0, s1_reg.a <= s1_reg.b};
            OP_SGT:  alu_r = {63'b0, slt_ba};
            OP_SGE:  alu_r = {63'b0, !slt_ab};
            OP_SLT:  alu_r = {63'b0, slt_ab};
            OP_SLE:  alu_r = {63'b0, !slt_ba};
            default: alu_r = '0;
        endcase
        if (dz_reg) begin
            div_r = '0;
        end else if (s1_reg.cmd == OP_UDIV || s1_reg.cmd == OP_SDIV) begin
            div_r = negq_reg ? (64'd0 - quo_reg) : quo_reg;
        end else begin
            div_r = negr_reg ? (64'd0 - rem_reg) : rem_reg;
        end
        final_r = s2_mul_reg ? (s2_pp0_reg + {s2_pp1_reg + s2_pp2_reg, 32'b0}) : s2_r_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= q_valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_go;
            end
            if (out_free) begin
                out_valid_reg <= s2_valid_reg;
            end
            cnt_reg <= cnt_next;
        end
        if (q_pop) begin
            s1_reg <= q_item;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        dz_reg   <= dz_next;
        if (s1_go) begin
            s2_mul_reg  <= (s1_reg.kind == KIND_MUL);
            s2_wsel_reg <= s1_reg.wsel;
            s2_r_reg    <= (s1_reg.kind == KIND_DIV) ? div_r : alu_r;
            s2_dz_reg   <= (s1_reg.kind == KIND_DIV) && dz_reg;
            // low 64 bits of the product from three 32x32 partial products
            s2_pp0_reg  <= s1_reg.a[31:0] * s1_reg.b[31:0];
            s2_pp1_reg  <= 32'(s1_reg.a[31:0] * s1_reg.b[63:32]);
            s2_pp2_reg  <= 32'(s1_reg.a[63:32] * s1_reg.b[31:0]);
        end
        if (out_free && s2_valid_reg) begin
            out_result_reg <= final_r & width_mask(s2_wsel_reg);
            out_dz_reg     <= s2_dz_reg;
        end
    end

    a_cnt_only_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> (s1_valid_reg && s1_reg.kind == KIND_DIV))
        else $error("divider busy without a divide item");

    a_no_early_go: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_go |-> (cnt_reg == '0))
        else $error("divide item left before the last step");

    a_dz_only_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_dz_reg) |-> !s2_mul_reg)
        else $error("zero-divisor flag on a non-divide item");

    a_pop_loads_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.kind == KIND_DIV && q_item.b != '0) |=> (cnt_reg == DIV_STEPS))
        else $error("divider not started on load");

endmodule

`default_nettype wire

// ===== design/sized_integer_alu.sv =====
// sized integer alu with divide
// input channel s_*: opcode, operand width select and two raw 64-bit operands
// result channel m_*: result cut to the width and zero-extended, plus a
// divide-by-zero flag; one result item per input item, in input order
// the front decodes and extends operands and writes a small queue; the back
// runs a two-stage execute pipeline and an output register
// path to m_valid: queue, both execute stages, then the output register
// throughput: one item per cycle for logic, shift, add, compare and mul,
// while m_ready is high; mul is split into 32x32 partial products summed
// in the second stage; divide and remainder share a radix-2 divider:
// 64 iterations, and the item holds the first execute stage throughout;
// a zero divisor skips the iterations and gives 0 with the flag set
// while m_ready is low the pipeline and then the queue fill up; s_ready
// falls only when the queue is full
// reset (aresetn low at a clock edge) empties the queue and all stages
`default_nettype none

module sized_integer_alu
    import sia_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [4:0]      s_cmd,
    input  wire logic [2:0]      s_width_sel,
    input  wire logic [63:0]     s_operand_a,
    input  wire logic [63:0]     s_operand_b,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [63:0]          m_result,
    output logic                 m_div_by_zero
);

    alu_item_t front_item;
    alu_item_t head_item;
    logic      q_full, q_valid, q_pop;

    assign s_ready = !q_full;

    sia_front u_front (
        .s_cmd       (s_cmd),
        .s_width_sel (s_width_sel),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .item        (front_item)
    );

    sia_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head_item)
    );

    sia_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .m_div_by_zero (m_div_by_zero)
    );

endmodule

`default_nettype wire
